### rtl/fav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fav_pkg: shared types and codes for the frequency admission victim selector
// Operation codes, register indexes, history modes and the shared unit types.
// ----------------------------------------------------------------------------
package fav_pkg;

  typedef enum logic [1:0] {
    ALU_INC,
    ALU_SUB,
    ALU_CMP
  } alu_op_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } alu_flags_t;

  localparam logic [2:0] FN_LOOKUP = 3'd0;
  localparam logic [2:0] FN_EPOCH  = 3'd1;
  localparam logic [2:0] FN_TOUCH  = 3'd2;
  localparam logic [2:0] FN_REMOVE = 3'd3;
  localparam logic [2:0] FN_VICTIM = 3'd4;

  localparam logic [1:0] MODE_EPOCH  = 2'd1;
  localparam logic [1:0] MODE_WINDOW = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_MIN    = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

endpackage

### rtl/fav_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fav_alu: shared count arithmetic unit
// Saturating increment, floor-at-zero subtract and magnitude compare.
// ----------------------------------------------------------------------------
module fav_alu import fav_pkg::*; #(
  parameter int CW = 32,
  parameter int AW = 32
) (
  input  alu_op_t         op,
  input  logic [AW-1:0]   a,
  input  logic [AW-1:0]   b,
  output logic [AW-1:0]   res,
  output alu_flags_t      flags
);

  localparam logic [AW:0]   ONE_SH = (AW+1)'(1) << CW;
  localparam logic [AW-1:0] CMAX   = AW'(ONE_SH - (AW+1)'(1));

  always_comb begin
    flags.lt = (a < b);
    flags.eq = (a == b);
    case (op)
      ALU_INC: res = (a >= CMAX) ? CMAX : a + AW'(1);
      ALU_SUB: res = (a <= b) ? '0 : a - b;
      default: res = a;
    endcase
  end

endmodule

### rtl/frequency_admission_victim_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_admission_victim_select: LFU replacement with admission threshold
// Windowed lookup clears the counters of a newly allocated epoch slot, victim select
// scans every cache slot, a windowed epoch start prunes expired epoch slots and a
// clearing epoch start clears the total counters and frees all epoch slots.
// One word at a time; next word taken the cycle after the result register loads.
// Reset (sync, low) clears the total counter RAM while no input is taken.
// ----------------------------------------------------------------------------
module frequency_admission_victim_select import fav_pkg::*; #(
  parameter int NUM_OBJECTS = 256,
  parameter int CACHE_SLOTS = 16,
  parameter int EPOCH_SLOTS = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] obj, [23:8] epoch, [27:24] slot, [59:28] stamp
  input  logic [63:0] in_tdata,
  // [2:0] func
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] count, [32] admit, [33] victim_valid, [37:34] victim_slot,
  // [45:38] victim_object, [46] epoch_overflow
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int OBJ_W = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int SL_W  = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int EP_W  = (EPOCH_SLOTS > 1) ? $clog2(EPOCH_SLOTS) : 1;
  localparam int CW    = COUNT_WIDTH;
  localparam int AW    = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
  localparam int EA_W  = EP_W + OBJ_W;
  localparam int EPD   = EPOCH_SLOTS * (2 ** OBJ_W);

  typedef enum logic [3:0] {
    S_TCLR, S_IDLE, S_DISP, S_LK_INC, S_EP_CLR, S_EP_RD, S_EP_INC,
    S_PR_CHK, S_PR_RD, S_PR_WR, S_VS_RD, S_VS_CMP, S_FIN, S_CNT, S_OUT
  } state_t;

  function automatic logic [OBJ_W-1:0] obj_idx(input logic [7:0] id);
    logic [OBJ_W-1:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      if (id == 8'(i)) r = OBJ_W'(i % NUM_OBJECTS);
    end
    return r;
  endfunction

  // configuration
  logic [1:0]  mode_r;
  logic [31:0] min_r;
  logic [3:0]  win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      min_r  <= '0;
      win_r  <= 4'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_paddr[3:2])
        REG_MODE:   mode_r <= cfg_pwdata[1:0];
        REG_MIN:    min_r  <= cfg_pwdata;
        REG_WINDOW: win_r  <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MODE:   cfg_prdata = {30'd0, mode_r};
      REG_MIN:    cfg_prdata = min_r;
      REG_WINDOW: cfg_prdata = {28'd0, win_r};
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

  // state
  state_t            state_r;
  logic [2:0]        func_r;
  logic [7:0]        objid_r;
  logic [OBJ_W-1:0]  obj_r;
  logic [15:0]       epoch_r;
  logic [3:0]        slot_r;
  logic [31:0]       atime_r;
  logic [OBJ_W-1:0]  o_r;
  logic [EP_W-1:0]   e_r;
  logic [SL_W-1:0]   s_r;
  logic              clr_item_r;
  logic [15:0]       tag_r   [EPOCH_SLOTS];
  logic              inuse_r [EPOCH_SLOTS];
  logic              svalid_r [CACHE_SLOTS];
  logic [7:0]        sobj_r  [CACHE_SLOTS];
  logic [31:0]       stime_r [CACHE_SLOTS];
  logic              have_r;
  logic [CW-1:0]     bc_r;
  logic [31:0]       bt_r;
  logic [7:0]        bo_r;
  logic [SL_W-1:0]   bs_r;
  logic              vic_r;
  logic              ovf_r;
  logic [CW-1:0]     cnt_r;
  logic              out_tvalid_r;
  logic [47:0]       out_tdata_r;

  // counter memories
  logic [CW-1:0]    tot_mem [NUM_OBJECTS];
  logic [CW-1:0]    ep_mem  [EPD];
  logic             tot_we, ep_we;
  logic [OBJ_W-1:0] tot_wa, tot_ra;
  logic [EA_W-1:0]  ep_wa, ep_ra;
  logic [CW-1:0]    tot_wd, ep_wd, tot_rd_r, ep_rd_r;

  always_ff @(posedge clk) begin
    if (tot_we) tot_mem[tot_wa] <= tot_wd;
    tot_rd_r <= tot_mem[tot_ra];
  end

  always_ff @(posedge clk) begin
    if (ep_we) ep_mem[ep_wa] <= ep_wd;
    ep_rd_r <= ep_mem[ep_ra];
  end

  // shared unit
  alu_op_t     alu_op;
  logic [AW-1:0] alu_a, alu_b, alu_res;
  alu_flags_t  alu_flags;

  fav_alu #(.CW(CW), .AW(AW)) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .flags (alu_flags)
  );

  // epoch tag search: lowest matching and lowest free slot
  logic            hit, free;
  logic [EP_W-1:0] hit_e, free_e;

  always_comb begin
    hit = 1'b0; hit_e = '0; free = 1'b0; free_e = '0;
    for (int i = EPOCH_SLOTS - 1; i >= 0; i--) begin
      if (inuse_r[i] && tag_r[i] == epoch_r) begin
        hit = 1'b1; hit_e = EP_W'(i);
      end
      if (!inuse_r[i]) begin
        free = 1'b1; free_e = EP_W'(i);
      end
    end
  end

  logic prune;
  assign prune = inuse_r[e_r] &&
                 ({1'b0, tag_r[e_r]} + 17'(win_r) <= {1'b0, epoch_r});

  logic o_last, e_last, s_last;
  assign o_last = (o_r == OBJ_W'(NUM_OBJECTS - 1));
  assign e_last = (e_r == EP_W'(EPOCH_SLOTS - 1));
  assign s_last = (s_r == SL_W'(CACHE_SLOTS - 1));

  logic better;
  assign better = !have_r || alu_flags.lt ||
                  (alu_flags.eq && stime_r[s_r] < bt_r) ||
                  (alu_flags.eq && stime_r[s_r] == bt_r && sobj_r[s_r] < bo_r);

  logic [SL_W-1:0] tslot;
  assign tslot = SL_W'(slot_r);

  logic [AW-1:0] cnt_ext;
  assign cnt_ext = AW'(cnt_r);

  always_comb begin
    tot_we = 1'b0; tot_wa = o_r; tot_wd = '0; tot_ra = obj_r;
    ep_we  = 1'b0; ep_wa = {e_r, o_r}; ep_wd = '0; ep_ra = {e_r, obj_r};
    alu_op = ALU_CMP; alu_a = AW'(tot_rd_r); alu_b = AW'(bc_r);
    unique case (state_r)
      S_TCLR:   tot_we = 1'b1;
      S_LK_INC: begin
        alu_op = ALU_INC;
        tot_we = 1'b1; tot_wa = obj_r; tot_wd = CW'(alu_res);
      end
      S_EP_CLR: ep_we = 1'b1;
      S_EP_INC: begin
        alu_op = ALU_INC; alu_a = AW'(ep_rd_r);
        ep_we = 1'b1; ep_wa = {e_r, obj_r}; ep_wd = CW'(alu_res);
      end
      S_PR_RD: begin
        ep_ra = {e_r, o_r}; tot_ra = o_r;
      end
      S_PR_WR: begin
        alu_op = ALU_SUB; alu_b = AW'(ep_rd_r);
        tot_we = 1'b1; tot_wd = CW'(alu_res);
      end
      S_VS_RD:  tot_ra = obj_idx(sobj_r[s_r]);
      S_CNT: begin
        // is the incoming object strictly hotter than the coldest slot
        alu_a = AW'(bc_r); alu_b = AW'(tot_rd_r);
      end
      S_OUT: begin
        alu_a = cnt_ext; alu_b = AW'(min_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_TCLR;
      o_r          <= '0;
      clr_item_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < EPOCH_SLOTS; i++) inuse_r[i] <= 1'b0;
      for (int i = 0; i < CACHE_SLOTS; i++) svalid_r[i] <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_OUT) out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_TCLR: begin
          o_r <= o_r + 1'b1;
          if (o_last) state_r <= clr_item_r ? S_FIN : S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            func_r  <= in_tuser;
            objid_r <= in_tdata[7:0];
            obj_r   <= obj_idx(in_tdata[7:0]);
            epoch_r <= in_tdata[23:8];
            slot_r  <= in_tdata[27:24];
            atime_r <= in_tdata[59:28];
            ovf_r   <= 1'b0;
            have_r  <= 1'b0;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          unique case (func_r)
            FN_LOOKUP: state_r <= S_LK_INC;
            FN_EPOCH: begin
              if (mode_r == MODE_EPOCH) begin
                o_r        <= '0;
                clr_item_r <= 1'b1;
                for (int i = 0; i < EPOCH_SLOTS; i++) inuse_r[i] <= 1'b0;
                state_r    <= S_TCLR;
              end else if (mode_r == MODE_WINDOW) begin
                e_r     <= '0;
                state_r <= S_PR_CHK;
              end else begin
                state_r <= S_FIN;
              end
            end
            FN_TOUCH: begin
              if (32'(slot_r) < CACHE_SLOTS) begin
                svalid_r[tslot] <= 1'b1;
                sobj_r[tslot]   <= objid_r;
                stime_r[tslot]  <= atime_r;
              end
              state_r <= S_FIN;
            end
            FN_REMOVE: begin
              if (32'(slot_r) < CACHE_SLOTS) svalid_r[tslot] <= 1'b0;
              state_r <= S_FIN;
            end
            FN_VICTIM: begin
              s_r     <= '0;
              state_r <= S_VS_RD;
            end
            default: state_r <= S_FIN;
          endcase
        end
        S_LK_INC: begin
          if (mode_r == MODE_WINDOW) begin
            if (hit) begin
              e_r     <= hit_e;
              state_r <= S_EP_RD;
            end else if (free) begin
              inuse_r[free_e] <= 1'b1;
              tag_r[free_e]   <= epoch_r;
              e_r             <= free_e;
              o_r             <= '0;
              state_r         <= S_EP_CLR;
            end else begin
              ovf_r   <= 1'b1;
              state_r <= S_FIN;
            end
          end else begin
            state_r <= S_FIN;
          end
        end
        S_EP_CLR: begin
          o_r <= o_r + 1'b1;
          if (o_last) state_r <= S_EP_RD;
        end
        S_EP_RD:  state_r <= S_EP_INC;
        S_EP_INC: state_r <= S_FIN;
        S_PR_CHK: begin
          if (prune) begin
            o_r     <= '0;
            state_r <= S_PR_RD;
          end else if (e_last) begin
            state_r <= S_FIN;
          end else begin
            e_r <= e_r + 1'b1;
          end
        end
        S_PR_RD: state_r <= S_PR_WR;
        S_PR_WR: begin
          if (o_last) begin
            inuse_r[e_r] <= 1'b0;
            if (e_last) begin
              state_r <= S_FIN;
            end else begin
              e_r     <= e_r + 1'b1;
              state_r <= S_PR_CHK;
            end
          end else begin
            o_r     <= o_r + 1'b1;
            state_r <= S_PR_RD;
          end
        end
        S_VS_RD: state_r <= S_VS_CMP;
        S_VS_CMP: begin
          if (svalid_r[s_r] && better) begin
            have_r <= 1'b1;
            bc_r   <= tot_rd_r;
            bt_r   <= stime_r[s_r];
            bo_r   <= sobj_r[s_r];
            bs_r   <= s_r;
          end
          if (s_last) begin
            state_r <= S_FIN;
          end else begin
            s_r     <= s_r + 1'b1;
            state_r <= S_VS_RD;
          end
        end
        S_FIN: begin
          clr_item_r <= 1'b0;
          state_r    <= S_CNT;
        end
        S_CNT: begin
          cnt_r   <= tot_rd_r;
          vic_r   <= have_r && alu_flags.lt && (func_r == FN_VICTIM);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {1'b0, ovf_r,
                             vic_r ? bo_r : 8'd0,
                             vic_r ? 4'(bs_r) : 4'd0,
                             vic_r, !alu_flags.lt, cnt_ext[31:0]};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### rtl/fav_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fav_chk: port-level checks for the victim selector
// Watches the stream and configuration ports; bound to the top level.
// ----------------------------------------------------------------------------
module fav_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        cfg_pready
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one word in flight: no second accept right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on back-to-back cycles");

  // no victim means slot and object fields are zero
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[33] |-> out_tdata[45:34] == 12'd0)
    else $error("victim fields set without victim_valid");

  // overflow only comes from a lookup, a victim only from victim select
  a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[46] |-> !out_tdata[33])
    else $error("overflow and victim in one word");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind frequency_admission_victim_select fav_chk u_fav_chk (.*);

### test/tb_frequency_admission_victim_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frequency_admission_victim_select: self-checking bench for the LFU selector
// Directed and random words go in over the input stream while a local model
// of the access counters, epoch window and slot table predicts each result.
// The sender and the receiver both idle at random. Every result word is compared
// as a whole against its prediction, in order.
// ----------------------------------------------------------------------------
module tb_frequency_admission_victim_select;
  import fav_pkg::*;

  localparam int NOBJ = 256;
  localparam int NSLOT = 16;
  localparam int NEPOCH = 8;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        ovf;
    logic [7:0]  vobj;
    logic [3:0]  vslot;
    logic        vvalid;
    logic        admit;
    logic [31:0] count;
  } lfu_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  frequency_admission_victim_select dut (.*);

  // local copy of the block's state
  logic [1:0]  mode_q;
  logic [31:0] min_admit_q;
  logic [3:0]  window_q;
  logic [31:0] total_cnt [NOBJ];
  logic [15:0] ep_tag [NEPOCH];
  logic        ep_used [NEPOCH];
  logic [31:0] ep_cnt [NEPOCH][NOBJ];
  logic        sl_valid [NSLOT];
  logic [7:0]  sl_obj [NSLOT];
  logic [31:0] sl_time [NSLOT];

  lfu_result_t expected_results[$];
  int          mismatches;
  int          hold_cycles;
  int          burst_left;
  logic [15:0] cur_epoch;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

  // advances the local state by one word and returns the expected result
  function automatic lfu_result_t lfu_predict(logic [2:0] fn, logic [7:0] obj,
                                              logic [15:0] ep, logic [3:0] sl,
                                              logic [31:0] atime);
    lfu_result_t r;
    int          hit;
    int          best;
    logic [31:0] bc;
    logic [31:0] c;
    r = '0;
    hit = -1;
    best = -1;
    bc = '0;
    case (fn)
      FN_LOOKUP: begin
        total_cnt[obj] = sat_inc(total_cnt[obj]);
        if (mode_q == MODE_WINDOW) begin
          for (int e = 0; e < NEPOCH; e++)
            if (hit < 0 && ep_used[e] && ep_tag[e] == ep) hit = e;
          for (int e = 0; e < NEPOCH; e++)
            if (hit < 0 && !ep_used[e]) begin
              hit = e;
              ep_used[e] = 1'b1;
              ep_tag[e] = ep;
              for (int o = 0; o < NOBJ; o++) ep_cnt[e][o] = '0;
            end
          if (hit < 0) r.ovf = 1'b1;
          else ep_cnt[hit][obj] = sat_inc(ep_cnt[hit][obj]);
        end
      end
      FN_EPOCH: begin
        if (mode_q == MODE_EPOCH) begin
          for (int o = 0; o < NOBJ; o++) total_cnt[o] = '0;
          for (int e = 0; e < NEPOCH; e++) begin
            ep_used[e] = 1'b0;
            for (int o = 0; o < NOBJ; o++) ep_cnt[e][o] = '0;
          end
        end else if (mode_q == MODE_WINDOW) begin
          for (int e = 0; e < NEPOCH; e++)
            if (ep_used[e] && ({1'b0, ep_tag[e]} + 17'(window_q) <= {1'b0, ep})) begin
              for (int o = 0; o < NOBJ; o++)
                total_cnt[o] = (total_cnt[o] <= ep_cnt[e][o]) ? '0
                                                              : total_cnt[o] - ep_cnt[e][o];
              ep_used[e] = 1'b0;
            end
        end
      end
      FN_TOUCH: begin
        sl_valid[sl] = 1'b1;
        sl_obj[sl] = obj;
        sl_time[sl] = atime;
      end
      FN_REMOVE: sl_valid[sl] = 1'b0;
      FN_VICTIM: begin
        for (int s = 0; s < NSLOT; s++)
          if (sl_valid[s]) begin
            c = total_cnt[sl_obj[s]];
            if (best < 0 || c < bc ||
                (c == bc && sl_time[s] < sl_time[best]) ||
                (c == bc && sl_time[s] == sl_time[best] && sl_obj[s] < sl_obj[best])) begin
              best = s;
              bc = c;
            end
          end
        if (best >= 0 && total_cnt[obj] > bc) begin
          r.vvalid = 1'b1;
          r.vslot = 4'(best);
          r.vobj = sl_obj[best];
        end
      end
      default: ;
    endcase
    r.count = total_cnt[obj];
    r.admit = (total_cnt[obj] >= min_admit_q);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    lfu_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tdata !== {1'b0, exp_r}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected cnt=%h adm=%b vv=%b vs=%0d vo=%h ovf=%b, got %h",
                     exp_r.count, exp_r.admit, exp_r.vvalid, exp_r.vslot, exp_r.vobj,
                     exp_r.ovf, out_tdata);
        end
      end
    end
  end

  // receiver: each phase draws a new stall rate, long hold on request
  initial begin
    int pct;
    int phase_cnt;
    pct = 0;
    phase_cnt = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_cnt == 0) begin
        phase_cnt = 64;
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 20;
          2: pct = 50;
          default: pct = 85;
        endcase
      end
      phase_cnt--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  // drops valid so a burst's last word is not taken twice, then waits
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_MODE:   mode_q = val[1:0];
      REG_MIN:    min_admit_q = val;
      REG_WINDOW: window_q = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    burst_left = 0;
  endtask

  // sends one word; valid stays high inside a burst, drops for a gap after it
  task automatic send_word(logic [2:0] fn, logic [7:0] obj, logic [15:0] ep,
                           logic [3:0] sl, logic [31:0] atime);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= {4'b0, atime, sl, ep, obj};
    do @(posedge clk); while (!in_tready);
    expected_results = {expected_results, lfu_predict(fn, obj, ep, sl, atime)};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
  endtask

  task automatic send_random(int n);
    logic [2:0]  fn;
    logic [7:0]  obj;
    logic [15:0] ep;
    int          w;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      if (w < 45) fn = FN_LOOKUP;
      else if (w < 50) fn = FN_EPOCH;
      else if (w < 65) fn = FN_TOUCH;
      else if (w < 70) fn = FN_REMOVE;
      else if (w < 95) fn = FN_VICTIM;
      else fn = 3'($urandom_range(5, 7));
      // a small hot set makes counts collide and victims meaningful
      obj = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
      if (fn == FN_EPOCH) cur_epoch = cur_epoch + 16'($urandom_range(0, 3));
      ep = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                        : cur_epoch - 16'($urandom_range(0, 2));
      send_word(fn, obj, ep, 4'($urandom), $urandom_range(0, 9) == 0 ? $urandom
                                                                       : $urandom_range(0, 20));
    end
  endtask

  task automatic test_empty_and_cumulative();
    send_word(FN_VICTIM, 8'd3, 16'd0, 4'd0, 32'd0);
    send_word(FN_LOOKUP, 8'd0, 16'd0, 4'd0, 32'd0);
    send_word(FN_LOOKUP, 8'hFF, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
    send_word(3'd5, 8'hFF, 16'd0, 4'd0, 32'd0);
    send_word(3'd7, 8'd0, 16'd0, 4'd0, 32'd0);
    // two slots tied on count, time and object: lower index wins
    send_word(FN_TOUCH, 8'd9, 16'd0, 4'hF, 32'd7);
    send_word(FN_TOUCH, 8'd9, 16'd0, 4'd2, 32'd7);
    send_word(FN_VICTIM, 8'hFF, 16'd0, 4'd0, 32'd0);
    send_word(FN_TOUCH, 8'd0, 16'd0, 4'd0, 32'hFFFF_FFFF);
    send_word(FN_VICTIM, 8'hFF, 16'd0, 4'd0, 32'd0);
    send_word(FN_REMOVE, 8'd0, 16'd0, 4'd2, 32'd0);
    send_word(FN_REMOVE, 8'd0, 16'd0, 4'hF, 32'd0);
    send_word(FN_VICTIM, 8'hFF, 16'd0, 4'd0, 32'd0);
    write_reg(REG_MIN, 32'hFFFF_FFFF);
    send_word(FN_LOOKUP, 8'hFF, 16'd0, 4'd0, 32'd0);
    write_reg(REG_MIN, 32'd2);
    send_word(FN_LOOKUP, 8'hFF, 16'd0, 4'd0, 32'd0);
    write_reg(REG_MODE, 2'd3);
    send_word(FN_EPOCH, 8'hFF, 16'd5, 4'd0, 32'd0);
  endtask

  task automatic test_epoch_clear();
    write_reg(REG_MODE, MODE_EPOCH);
    send_word(FN_LOOKUP, 8'd4, 16'd1, 4'd0, 32'd0);
    send_word(FN_EPOCH, 8'd4, 16'd2, 4'd0, 32'd0);
    send_word(FN_LOOKUP, 8'hFF, 16'd2, 4'd0, 32'd0);
  endtask

  task automatic test_window();
    write_reg(REG_MODE, MODE_WINDOW);
    write_reg(REG_WINDOW, 4'd2);
    // nine distinct epochs overrun the eight epoch slots
    for (int e = 1; e <= 9; e++) send_word(FN_LOOKUP, 8'(e), 16'(e), 4'd0, 32'd0);
    send_word(FN_EPOCH, 8'd1, 16'd10, 4'd0, 32'd0);
    send_word(FN_LOOKUP, 8'd8, 16'hFFFF, 4'd0, 32'd0);
    write_reg(REG_WINDOW, 4'd8);
    // tag plus window must not wrap past the top epoch
    send_word(FN_EPOCH, 8'd8, 16'hFFFF, 4'd0, 32'd0);
  endtask

  task automatic test_random();
    write_reg(REG_MODE, 2'd0);
    write_reg(REG_MIN, 32'd0);
    cur_epoch = 16'd20;
    send_random(200);
    write_reg(REG_MODE, MODE_EPOCH);
    write_reg(REG_MIN, 32'd3);
    send_random(150);
    write_reg(REG_MODE, MODE_WINDOW);
    write_reg(REG_WINDOW, 4'd1);
    send_random(150);
    write_reg(REG_WINDOW, 4'd8);
    write_reg(REG_MIN, 32'hFFFF_FFFF);
    send_random(150);
    write_reg(REG_WINDOW, 4'd3);
    write_reg(REG_MODE, 2'd3);
    send_random(150);
  endtask

  task automatic test_backpressure();
    write_reg(REG_MODE, 2'd0);
    hold_cycles = 600;
    burst_left = 40;
    send_random(40);
    wait_drained();
    send_random(20);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    hold_cycles = 0;
    burst_left = 0;
    cur_epoch = '0;
    mode_q = '0;
    min_admit_q = '0;
    window_q = 4'd1;
    for (int o = 0; o < NOBJ; o++) total_cnt[o] = '0;
    for (int e = 0; e < NEPOCH; e++) begin
      ep_tag[e] = '0;
      ep_used[e] = 1'b0;
      for (int o = 0; o < NOBJ; o++) ep_cnt[e][o] = '0;
    end
    for (int s = 0; s < NSLOT; s++) begin
      sl_valid[s] = 1'b0;
      sl_obj[s] = '0;
      sl_time[s] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_and_cumulative();
    test_epoch_clear();
    test_window();
    test_random();
    test_backpressure();

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fav_pkg.sv
rtl/fav_alu.sv
rtl/frequency_admission_victim_select.sv
rtl/fav_chk.sv
test/tb_frequency_admission_victim_select.sv
